/* rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescape block.
// Used by the front decoder, the job queue, the back serialiser and the top level.
`default_nettype none
package jsu_pkg;

    localparam int unsigned MAX_LEN = 4096;
    localparam int unsigned QDEPTH  = 4;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_ESCAPE   = 3'd1;
    localparam logic [2:0] E_HEX      = 3'd2;
    localparam logic [2:0] E_SURR     = 3'd3;
    localparam logic [2:0] E_OVERFLOW = 3'd4;
    localparam logic [2:0] E_CONTROL  = 3'd5;
    localparam logic [2:0] E_TEXT     = 3'd6;
    localparam logic [2:0] E_CUT      = 3'd7;

    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_END  = 1'b1;

    typedef struct packed {
        logic            is_done;
        logic [2:0]      n;
        logic [3:0][7:0] b;
        logic            ok;
        logic [2:0]      cause;
        logic [12:0]     len;
    } t_job;

endpackage
`default_nettype wire

/* rtl/jsu_front.sv */
// Front decoder: accepts body bytes, decodes escapes, runs the UTF-8 text check
// and pushes a job for each item that yields bytes and for the end item. Depends on jsu_pkg.
`default_nettype none
module jsu_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_opcode,
    input  wire  [7:0]        i_byte,
    input  wire  [12:0]       i_capacity,
    input  wire               i_allow_ws,
    input  wire               i_q_full,
    output logic              o_push,
    output jsu_pkg::t_job     o_job
);
    import jsu_pkg::*;

    typedef enum logic [11:0] {
        P_TEXT = 12'b000000000001,
        P_ESC  = 12'b000000000010,
        P_U1   = 12'b000000000100,
        P_U2   = 12'b000000001000,
        P_U3   = 12'b000000010000,
        P_U4   = 12'b000000100000,
        P_HI   = 12'b000001000000,
        P_BS   = 12'b000010000000,
        P_L1   = 12'b000100000000,
        P_L2   = 12'b001000000000,
        P_L3   = 12'b010000000000,
        P_L4   = 12'b100000000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_hex, n_hex;
    logic [9:0]  r_high, n_high;
    logic [12:0] r_count, n_count;
    logic [1:0]  r_pend, n_pend;
    logic [20:0] r_code, n_code;
    logic [1:0]  r_extra, n_extra;
    logic [2:0]  r_err, n_err;

    logic        accept;
    logic [13:0] limit;
    logic [4:0]  hexd;
    logic [15:0] hexn;
    logic [20:0] cp;
    logic        do_emit;
    logic [3:0][7:0] eb;
    logic [2:0]  en;
    logic        stop;
    logic [2:0]  k;
    logic [7:0]  cb;
    logic [20:0] fl;
    logic        good;
    logic [2:0]  cause;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign limit   = (i_capacity > 13'(MAX_LEN)) ? 14'(MAX_LEN) : {1'b0, i_capacity};

    always_comb begin
        if (i_byte >= 8'h30 && i_byte <= 8'h39)      hexd = {1'b1, i_byte[3:0]};
        else if ((i_byte >= 8'h61 && i_byte <= 8'h66) || (i_byte >= 8'h41 && i_byte <= 8'h46))
            hexd = {1'b1, i_byte[3:0] + 4'd9};
        else                                         hexd = 5'd0;
    end
    assign hexn = {r_hex[11:0], hexd[3:0]};

    always_comb begin
        n_phase = r_phase; n_hex = r_hex; n_high = r_high; n_count = r_count;
        n_pend = r_pend; n_code = r_code; n_extra = r_extra; n_err = r_err;
        do_emit = 1'b0; eb = '0; en = 3'd0; cp = 21'd0;
        o_push = 1'b0; o_job = '0; stop = 1'b0; k = 3'd0; cb = 8'd0;
        fl = 21'd0; good = 1'b0; cause = r_err;
        if (accept) begin
            if (i_opcode == OP_END) begin
                if (cause == E_NONE) begin
                    if (r_phase == P_HI)        cause = E_SURR;
                    else if (r_phase != P_TEXT) cause = E_CUT;
                    else if (r_pend != 2'd0)    cause = E_TEXT;
                end
                o_push = 1'b1;
                o_job.is_done = 1'b1;
                o_job.ok = (cause == E_NONE);
                o_job.cause = cause;
                o_job.len = r_count;
                n_phase = P_TEXT; n_hex = '0; n_high = '0; n_count = '0;
                n_pend = '0; n_code = '0; n_extra = '0; n_err = E_NONE;
            end else if (r_err == E_NONE) begin
                if (r_phase == P_ESC) begin
                    n_phase = P_TEXT;
                    do_emit = 1'b1; en = 3'd1;
                    case (i_byte)
                        8'h22, 8'h5C, 8'h2F: eb[0] = i_byte;
                        8'h62: eb[0] = 8'h08;
                        8'h66: eb[0] = 8'h0C;
                        8'h6E: eb[0] = 8'h0A;
                        8'h72: eb[0] = 8'h0D;
                        8'h74: eb[0] = 8'h09;
                        8'h75: begin
                            do_emit = 1'b0; n_phase = P_U1; n_hex = '0;
                        end
                        default: begin
                            do_emit = 1'b0; n_phase = r_phase; n_err = E_ESCAPE;
                        end
                    endcase
                end else if (i_byte < 8'h20) begin
                    n_err = E_CONTROL;
                end else begin
                    unique case (r_phase)
                        P_TEXT: begin
                            if (i_byte == 8'h5C) n_phase = P_ESC;
                            else begin
                                do_emit = 1'b1; en = 3'd1; eb[0] = i_byte;
                            end
                        end
                        P_HI: begin
                            if (i_byte != 8'h5C) n_err = E_SURR;
                            else                 n_phase = P_BS;
                        end
                        P_BS: begin
                            if (i_byte != 8'h75) n_err = E_SURR;
                            else begin
                                n_phase = P_L1; n_hex = '0;
                            end
                        end
                        P_U1, P_U2, P_U3, P_L1, P_L2, P_L3: begin
                            if (!hexd[4]) n_err = E_HEX;
                            else begin
                                n_hex = hexn;
                                n_phase = t_phase'({r_phase[10:0], 1'b0});
                            end
                        end
                        P_U4: begin
                            if (!hexd[4]) n_err = E_HEX;
                            else begin
                                n_hex = hexn;
                                if (hexn >= 16'hD800 && hexn <= 16'hDBFF) begin
                                    n_high = hexn[9:0]; n_phase = P_HI;
                                end else if (hexn >= 16'hDC00 && hexn <= 16'hDFFF) begin
                                    n_err = E_SURR;
                                end else begin
                                    n_phase = P_TEXT; do_emit = 1'b1; cp = {5'd0, hexn};
                                end
                            end
                        end
                        P_L4: begin
                            if (!hexd[4]) n_err = E_HEX;
                            else begin
                                n_hex = hexn;
                                if (hexn < 16'hDC00 || hexn > 16'hDFFF) n_err = E_SURR;
                                else begin
                                    n_phase = P_TEXT; do_emit = 1'b1;
                                    cp = 21'h10000 + {1'b0, r_high, hexn[9:0]};
                                end
                            end
                        end
                        default: n_phase = P_TEXT;
                    endcase
                    if (do_emit && en == 3'd0) begin
                        if (cp < 21'h80) begin
                            eb[0] = cp[7:0]; en = 3'd1;
                        end else if (cp < 21'h800) begin
                            eb[0] = {3'b110, cp[10:6]}; eb[1] = {2'b10, cp[5:0]}; en = 3'd2;
                        end else if (cp < 21'h10000) begin
                            eb[0] = {4'b1110, cp[15:12]}; eb[1] = {2'b10, cp[11:6]};
                            eb[2] = {2'b10, cp[5:0]}; en = 3'd3;
                        end else begin
                            eb[0] = {5'b11110, cp[20:18]}; eb[1] = {2'b10, cp[17:12]};
                            eb[2] = {2'b10, cp[11:6]}; eb[3] = {2'b10, cp[5:0]}; en = 3'd4;
                        end
                    end
                end
                if (do_emit) begin
                    if ({1'b0, r_count} + 14'(en) > limit) begin
                        n_err = E_OVERFLOW;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            if (!stop && 3'(i) < en) begin
                                cb = eb[i];
                                good = 1'b0;
                                if (cb[7:6] == 2'b10) begin
                                    if (n_pend != 2'd0) begin
                                        n_code = {n_code[14:0], cb[5:0]};
                                        n_pend = n_pend - 2'd1;
                                        if (n_pend != 2'd0) good = 1'b1;
                                        else begin
                                            fl = (n_extra == 2'd1) ? 21'h80 :
                                                 (n_extra == 2'd2) ? 21'h800 : 21'h10000;
                                            good = !(n_code < fl || n_code > 21'h10FFFF ||
                                                     (n_code >= 21'hD800 && n_code <= 21'hDFFF));
                                        end
                                    end
                                end else if (n_pend == 2'd0) begin
                                    if (!cb[7]) begin
                                        good = (cb >= 8'h20 && cb != 8'h7F) ||
                                               (i_allow_ws &&
                                                (cb == 8'h09 || cb == 8'h0A || cb == 8'h0D));
                                    end else if (cb[7:5] == 3'b110) begin
                                        n_extra = 2'd1; n_code = {16'd0, cb[4:0]};
                                        n_pend = 2'd1; good = 1'b1;
                                    end else if (cb[7:4] == 4'b1110) begin
                                        n_extra = 2'd2; n_code = {17'd0, cb[3:0]};
                                        n_pend = 2'd2; good = 1'b1;
                                    end else if (cb[7:3] == 5'b11110) begin
                                        n_extra = 2'd3; n_code = {18'd0, cb[2:0]};
                                        n_pend = 2'd3; good = 1'b1;
                                    end
                                end
                                if (!good) begin
                                    stop = 1'b1; n_err = E_TEXT;
                                end else begin
                                    k = k + 3'd1;
                                end
                            end
                        end
                        n_count = r_count + 13'(k);
                        if (k != 3'd0) begin
                            o_push = 1'b1;
                            o_job.n = k;
                            o_job.b = eb;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_TEXT; r_hex <= '0; r_high <= '0; r_count <= '0;
            r_pend <= '0; r_code <= '0; r_extra <= '0; r_err <= E_NONE;
        end else begin
            r_phase <= n_phase; r_hex <= n_hex; r_high <= n_high; r_count <= n_count;
            r_pend <= n_pend; r_code <= n_code; r_extra <= n_extra; r_err <= n_err;
        end
    end
endmodule
`default_nettype wire

/* rtl/jsu_queue.sv */
// Job queue between the front decoder and the back serialiser.
// Depends on jsu_pkg for the job type and depth.
`default_nettype none
module jsu_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  jsu_pkg::t_job     i_job,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_empty,
    output jsu_pkg::t_job     o_job
);
    import jsu_pkg::*;

    localparam int unsigned AW = $clog2(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + AW'(1);
            if (do_pop)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/jsu_back.sv */
// Back serialiser: takes jobs from the queue and sends one result item a cycle
// through an output register while i_tready is high and a job waits. Depends on jsu_pkg.
`default_nettype none
module jsu_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_empty,
    input  jsu_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_tvalid,
    input  wire               i_tready,
    output logic [31:0]       o_tdata,
    output logic              o_tuser,
    output logic              o_tlast
);
    import jsu_pkg::*;

    logic        r_valid;
    logic [1:0]  r_idx;
    logic [31:0] r_data;
    logic        r_user, r_last;
    logic        load, last_of_job;

    assign load        = !i_empty && (!r_valid || i_tready);
    assign last_of_job = i_job.is_done || ({1'b0, r_idx} + 3'd1 == i_job.n);
    assign o_pop       = load && last_of_job;
    assign o_tvalid    = r_valid;
    assign o_tdata     = r_data;
    assign o_tuser     = r_user;
    assign o_tlast     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_idx <= '0;
        end else begin
            if (load)           r_valid <= 1'b1;
            else if (i_tready)  r_valid <= 1'b0;
            if (load) r_idx <= last_of_job ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_job.is_done) begin
                r_data <= {7'd0, i_job.len, i_job.cause, i_job.ok, 8'd0};
                r_user <= 1'b0; r_last <= 1'b1;
            end else begin
                r_data <= {24'd0, i_job.b[r_idx]};
                r_user <= 1'b1; r_last <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/json_string_unescape_utf8_check.sv */
// JSON string body decoder with UTF-8 check: top level with the APB register port.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
// Input stream: one item per body byte, tuser = 0 and tdata = the byte; an item
// with tuser = 1 ends the string. Output stream: one item per decoded byte
// (tuser = 1), then one status item (tuser = 0, tlast = 1) with ok, cause and
// length. A byte produces up to four output items.
// Path: the decoder pushes each job into the queue, and the back serialiser loads it into the output register.
// Throughput: one input item a cycle while the four-job queue has room; the
// output side sends one item a cycle while m_tready is high, so a four-byte
// code point occupies the output register for four items and the queue absorbs the burst.
// Reset: decoder state clears, capacity returns to 4096, whitespace allowed.
// Output stall: the output register holds its item; the queue fills, then
// s_tready drops until the queue has room again.
// Registers: 0x0 output_capacity[12:0], 0x4 allow_whitespace[0]. Write only
// while idle.
`default_nettype none
module json_string_unescape_utf8_check (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // in_byte[7:0]
    input  wire         s_tuser,   // opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // out_byte[7:0], ok[8], error_cause[11:9], out_length[24:12]
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast,   // done_res
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jsu_pkg::*;

    logic [12:0] r_cap;
    logic        r_ws;
    logic        full, empty, push, pop;
    t_job        fjob, qjob;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {31'd0, r_ws} : {19'd0, r_cap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 13'd4096; r_ws <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_ws <= pwdata[0];
            else          r_cap <= pwdata[12:0];
        end
    end

    jsu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_tvalid), .o_ready(s_tready),
        .i_opcode(s_tuser), .i_byte(s_tdata),
        .i_capacity(r_cap), .i_allow_ws(r_ws),
        .i_q_full(full), .o_push(push), .o_job(fjob)
    );

    jsu_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_job(fjob), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(qjob)
    );

    jsu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_job(qjob), .o_pop(pop),
        .o_tvalid(m_tvalid), .i_tready(m_tready),
        .o_tdata(m_tdata), .o_tuser(m_tuser), .o_tlast(m_tlast)
    );
endmodule
`default_nettype wire
